// ----- src/bf5_pkg.sv -----
// ----------------------------------------------------------------------------
// bf5_pkg
// shared types and constants of the 5x5 box filter
// ----------------------------------------------------------------------------
package bf5_pkg;

    // default image limits
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    // field and register widths
    localparam int PIX_W    = 8;
    localparam int POS_W    = 10;
    localparam int CFG_W    = 11;
    localparam int COLSUM_W = 11;
    localparam int TOTAL_W  = 13;

    // window geometry
    localparam int WIN      = 5;
    localparam int HALF     = 2;
    localparam int AREA     = 25;
    localparam int MIN_SIZE = 5;

    // reciprocal of the window area, exact for totals up to 25 * 255
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT + AREA - 1) / AREA;

    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // control of the window cells
    typedef struct packed {
        logic clear;
        logic shift;
    } t_cell_ctl;

endpackage

// ----- src/bf5_pix_if.sv -----
// ----------------------------------------------------------------------------
// bf5_pix_if
// pixel input channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bf5_pix_if;
    logic                       valid;
    logic                       ready;
    logic [bf5_pkg::PIX_W-1:0]  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

// ----- src/bf5_res_if.sv -----
// ----------------------------------------------------------------------------
// bf5_res_if
// filtered result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface bf5_res_if;
    logic                       valid;
    logic                       ready;
    logic [bf5_pkg::PIX_W-1:0]  mean_value;
    logic [bf5_pkg::POS_W-1:0]  centre_row;
    logic [bf5_pkg::POS_W-1:0]  centre_col;
    logic                       last_interior;

    modport source (output valid, output mean_value, output centre_row,
                    output centre_col, output last_interior, input ready);
    modport sink   (input valid, input mean_value, input centre_row,
                    input centre_col, input last_interior, output ready);
endinterface

// ----- src/bf5_ram.sv -----
// ----------------------------------------------------------------------------
// bf5_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bf5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/bf5_cell.sv -----
// ----------------------------------------------------------------------------
// bf5_cell
// one column sum of the window, takes its neighbor's sum on a shift
// ----------------------------------------------------------------------------
module bf5_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bf5_pkg::t_cell_ctl            i_ctl,
    input  logic [bf5_pkg::COLSUM_W-1:0]  i_sum,
    output logic [bf5_pkg::COLSUM_W-1:0]  o_sum
);
    logic [bf5_pkg::COLSUM_W-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (i_ctl.shift) begin
            r_sum <= i_sum;
        end
    end

    assign o_sum = r_sum;
endmodule

// ----- src/bf5_div25.sv -----
// ----------------------------------------------------------------------------
// bf5_div25
// division of the window total by 25 through a registered reciprocal product
// ----------------------------------------------------------------------------
module bf5_div25 (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [bf5_pkg::TOTAL_W-1:0]  i_total,
    output logic [bf5_pkg::PIX_W-1:0]    o_mean
);
    localparam int MUL_W  = $clog2(bf5_pkg::RECIP_MUL + 1);
    localparam int PROD_W = bf5_pkg::TOTAL_W + MUL_W;

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_total) * PROD_W'(bf5_pkg::RECIP_MUL);
        end
    end

    assign o_mean = r_prod[bf5_pkg::RECIP_SHIFT +: bf5_pkg::PIX_W];
endmodule

// ----- src/box_filter_5x5_mean.sv -----
// ----------------------------------------------------------------------------
// box_filter_5x5_mean
// 5x5 mean filter on a raster pixel stream with four line buffers
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake      | payload
//  ---------+-----+----------------+-----------------------------------------
//  i_pix    | in  | valid / ready  | pixel
//  o_res    | out | valid / ready  | mean_value centre_row centre_col
//           |     |                |   last_interior
//  i_cfg_*  | in  | write enable   | image_width (0), image_height (1)
//
//  one pixel item per clock while the output register is not stalled; a
//  result passes the line store read, column sum, window cells, window
//  total, reciprocal multiply and output register stages
//  synchronous active-low reset clears counters, window cells and valids;
//  the line store is not cleared, so no clearing pass is needed
//  the whole pipeline advances together; it stalls only while the output
//  register holds an item that is not taken
//  a register write restarts the image at row 0, column 0
// ----------------------------------------------------------------------------
module box_filter_5x5_mean #(
    parameter int MAX_WIDTH  = bf5_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bf5_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bf5_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bf5_pkg::CFG_W-1:0]      i_cfg_data,
    bf5_pix_if.sink                        i_pix,
    bf5_res_if.source                      o_res
);
    // column and row counter widths
    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    // widths that hold the effective sizes and a register value
    localparam int SWW = ($clog2(MAX_WIDTH + 1) > bf5_pkg::CFG_W) ?
                         $clog2(MAX_WIDTH + 1) : bf5_pkg::CFG_W;
    localparam int SWH = ($clog2(MAX_HEIGHT + 1) > bf5_pkg::CFG_W) ?
                         $clog2(MAX_HEIGHT + 1) : bf5_pkg::CFG_W;
    // widths for the centre position before truncation
    localparam int PXW = (CW > bf5_pkg::POS_W) ? CW : bf5_pkg::POS_W;
    localparam int PYW = (RW > bf5_pkg::POS_W) ? RW : bf5_pkg::POS_W;
    localparam int PW  = bf5_pkg::PIX_W;
    localparam int LW  = PW * (bf5_pkg::WIN - 1);

    // position of an item travelling down the pipe
    typedef struct packed {
        logic [bf5_pkg::POS_W-1:0] row;
        logic [bf5_pkg::POS_W-1:0] col;
        logic                      last;
        logic                      emit;
    } t_meta;

    // ---------------- configuration registers ----------------
    logic [bf5_pkg::CFG_W-1:0] r_cfg_w;
    logic [bf5_pkg::CFG_W-1:0] r_cfg_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= bf5_pkg::CFG_RESET;
            r_cfg_h <= bf5_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (bf5_pkg::t_cfg_reg'(i_cfg_index))
                bf5_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                bf5_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
        end
    end

    // sizes clamped to the supported range
    logic [SWW-1:0] w_ext, w_eff;
    logic [SWH-1:0] h_ext, h_eff;

    always_comb begin
        w_ext = SWW'(r_cfg_w);
        h_ext = SWH'(r_cfg_h);
        if (w_ext < SWW'(bf5_pkg::MIN_SIZE)) begin
            w_eff = SWW'(bf5_pkg::MIN_SIZE);
        end else if (w_ext > SWW'(MAX_WIDTH)) begin
            w_eff = SWW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext < SWH'(bf5_pkg::MIN_SIZE)) begin
            h_eff = SWH'(bf5_pkg::MIN_SIZE);
        end else if (h_ext > SWH'(MAX_HEIGHT)) begin
            h_eff = SWH'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
    end

    // ---------------- handshake and position counters ----------------
    logic r_out_valid;
    logic adv;
    logic acc;

    // the pipe moves whenever the output register is free or being taken
    assign adv         = !r_out_valid || o_res.ready;
    assign i_pix.ready = adv;
    assign acc         = i_pix.valid && adv;

    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          col_last;
    logic          row_last;

    assign col_last = (SWW'(r_col) + SWW'(1)) >= w_eff;
    assign row_last = (SWH'(r_row) + SWH'(1)) >= h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    // position of the accepted pixel's window centre
    logic [PXW-1:0] centre_col_full;
    logic [PYW-1:0] centre_row_full;
    t_meta          meta0;

    assign centre_col_full = PXW'(r_col) - PXW'(bf5_pkg::HALF);
    assign centre_row_full = PYW'(r_row) - PYW'(bf5_pkg::HALF);

    always_comb begin
        meta0.row  = centre_row_full[bf5_pkg::POS_W-1:0];
        meta0.col  = centre_col_full[bf5_pkg::POS_W-1:0];
        meta0.last = row_last && col_last;
        // window complete once four rows and four columns are behind
        meta0.emit = (r_row >= RW'(bf5_pkg::WIN - 1)) &&
                     (r_col >= CW'(bf5_pkg::WIN - 1));
    end

    // ---------------- stage 1: line store read ----------------
    logic                           r1_valid;
    logic [PW-1:0]                  r1_pixel;
    logic [CW-1:0]                  r1_col;
    t_meta                          r1_meta;
    logic [LW-1:0]                  word;
    logic [bf5_pkg::COLSUM_W-1:0]   colsum;

    // bytes 0..3 hold the four rows above, newest in byte 0
    bf5_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (adv && r1_valid),
        .i_waddr (r1_col),
        .i_wdata ({word[LW-PW-1:0], r1_pixel}),
        .i_re    (acc),
        .i_raddr (r_col),
        .o_rdata (word)
    );

    always_comb begin
        colsum = bf5_pkg::COLSUM_W'(r1_pixel);
        for (int i = 0; i < bf5_pkg::WIN - 1; i++) begin
            colsum = colsum + bf5_pkg::COLSUM_W'(word[i*PW +: PW]);
        end
    end

    // ---------------- stage 2: column sum ----------------
    logic                           r2_valid;
    logic [bf5_pkg::COLSUM_W-1:0]   r2_colsum;
    t_meta                          r2_meta;

    // ---------------- stage 3: window cells ----------------
    logic                           r3_valid;
    t_meta                          r3_meta;
    bf5_pkg::t_cell_ctl             cell_ctl;
    logic [bf5_pkg::COLSUM_W-1:0]   cell_sum [bf5_pkg::WIN];
    logic [bf5_pkg::TOTAL_W-1:0]    total;

    assign cell_ctl.clear = i_cfg_we;
    assign cell_ctl.shift = adv && r2_valid;

    // newest column enters the last cell and moves toward cell 0
    for (genvar g = 0; g < bf5_pkg::WIN; g++) begin : g_cell
        bf5_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_sum   ((g == bf5_pkg::WIN - 1) ? r2_colsum : cell_sum[(g + 1) % bf5_pkg::WIN]),
            .o_sum   (cell_sum[g])
        );
    end

    always_comb begin
        total = '0;
        for (int i = 0; i < bf5_pkg::WIN; i++) begin
            total = total + bf5_pkg::TOTAL_W'(cell_sum[i]);
        end
    end

    // ---------------- stage 4: window total ----------------
    logic                           r4_valid;
    logic [bf5_pkg::TOTAL_W-1:0]    r4_total;
    t_meta                          r4_meta;

    // ---------------- stage 5: reciprocal product ----------------
    logic                           r5_valid;
    t_meta                          r5_meta;
    logic [PW-1:0]                  mean;

    bf5_div25 u_div25 (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_total (r4_total),
        .o_mean  (mean)
    );

    // ---------------- output register ----------------
    logic [PW-1:0]  r_out_mean;
    t_meta          r_out_meta;

    // valid bits; items with no result drop out on entering the window cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_valid    <= acc;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid && r2_meta.emit;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_pixel   <= i_pix.pixel;
            r1_col     <= r_col;
            r1_meta    <= meta0;
            r2_colsum  <= colsum;
            r2_meta    <= r1_meta;
            r3_meta    <= r2_meta;
            r4_total   <= total;
            r4_meta    <= r3_meta;
            r5_meta    <= r4_meta;
            r_out_mean <= mean;
            r_out_meta <= r5_meta;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.mean_value    = r_out_mean;
    assign o_res.centre_row    = r_out_meta.row;
    assign o_res.centre_col    = r_out_meta.col;
    assign o_res.last_interior = r_out_meta.last;

    // ---------------- assertions ----------------
    // a register write restarts the image position
    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0) && (r_row == '0))
        else $error("position not restarted after register write");

    // the line store word of a stalled item must not change
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r1_valid && !adv) |=> (r1_valid && $stable(word)))
        else $error("line store word lost during stall");

    // a result only appears when the product stage held one
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r5_valid))
        else $error("result without a product stage item");

endmodule
